// ----- rtl/b64sd_pkg.sv -----
// Package with the types, codes and character mapping of the base64 stream decoder.
`default_nettype none

package b64sd_pkg;

    // Depth of the result group queue between the decode stage and the output register.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character classes beyond the 64 alphabet values.
    localparam logic [6:0] CODE_SKIP = 7'd64;
    localparam logic [6:0] CODE_PAD  = 7'd65;
    localparam logic [6:0] CODE_BAD  = 7'd66;

    // Status codes of the final report.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    // Result kinds.
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    // Register indexes, taken from paddr[2].
    localparam logic REG_TARGET_CAPACITY = 1'b0;
    localparam logic REG_COUNT_ONLY      = 1'b1;

    // One queued group of results: up to three data bytes, then an optional report.
    typedef struct packed {
        logic [23:0] bytes;      // first byte in the top bits
        logic [1:0]  nbytes;
        logic        report;
        logic [1:0]  status;
        logic [31:0] count;
    } b64sd_group_t;

    // Maps a text byte to its 6-bit value or to one of the special classes.
    function automatic logic [6:0] map_char(input logic [7:0] ch);
        logic [6:0] code;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            code = 7'(ch - 8'h41);          // upper case letters
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            code = 7'(ch - 8'd71);          // lower case letters start at 26
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            code = 7'(ch + 8'd4);           // digits start at 52
        end else if (ch == 8'h2B) begin
            code = 7'd62;
        end else if (ch == 8'h2F) begin
            code = 7'd63;
        end else if (ch == 8'h0A) begin
            code = CODE_SKIP;
        end else if (ch == 8'h3D) begin
            code = CODE_PAD;
        end else begin
            code = CODE_BAD;
        end
        return code;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/base64_stream_decoder.sv -----
// Top level of the base64 stream decoder: input stage, decode logic, group queue, output register.
`default_nettype none

// The decoder takes one text character per transfer and accepts a new one in every cycle
// while its four-entry group queue has room. An accepted character is decoded while it is
// held in the input register; the bytes and the final report it causes are queued
// as one group and leave through the output register at one result transfer per cycle
// while the result side is ready. Sustained input rate is therefore one character per cycle,
// because four characters give at most three bytes; an end-of-text transfer adds one
// report transfer, and a stalled result side backs up through the queue to s_tready.
// An input transfer reaches its first result via the input register, queue and output register.
module base64_stream_decoder
    import b64sd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Input channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] char_code
    input  wire logic        s_tuser,    // [0] char_present
    input  wire logic        s_tlast,    // end_of_text

    // Result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,    // [7:0] data_byte, [9:8] status_code,
                                         // [41:10] byte_count, [47:42] zero
    output logic             m_tuser,    // [0] result_kind
    output logic             m_tlast,    // last_of_run

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    // Configuration registers
    logic [31:0] capacity_reg;
    logic        count_only_reg;

    // Input stage
    logic       st_valid_reg;
    logic [7:0] st_char_reg;
    logic       st_present_reg;
    logic       st_end_reg;

    // Decoder state
    logic [17:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] total_reg, total_next;
    logic        stopped_reg, stopped_next;
    logic [1:0]  err_reg, err_next;

    // Decode logic
    logic [6:0]  code;
    logic        char_live;
    logic        is_end;
    logic        group_evt;
    logic        flush3;
    logic        flush2;
    logic [17:0] buf_mid;
    logic [1:0]  cnt_mid;
    logic        stop_mid;
    logic [1:0]  err_mid;
    logic [1:0]  take_n;
    logic [32:0] sum;
    logic        over;
    logic        emit;
    logic [31:0] total_mid;
    logic [1:0]  err_fin;
    logic        stop_fin;
    b64sd_group_t grp;
    logic        push;

    // Group queue
    b64sd_group_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   qcnt_reg;
    logic                     pop;
    b64sd_group_t             head;

    // Output side
    logic [1:0]  idx_reg;
    logic [2:0]  nres;
    logic        res_last;
    logic        load;
    logic        m_valid_reg;
    logic        m_kind_reg;
    logic [7:0]  m_byte_reg;
    logic [1:0]  m_status_reg;
    logic [31:0] m_count_reg;
    logic        m_last_reg;
    logic [7:0]  sel_byte;

    // Configuration writes and reads.
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg   <= '0;
            count_only_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (paddr[2])
                REG_TARGET_CAPACITY: capacity_reg   <= pwdata;
                REG_COUNT_ONLY:      count_only_reg <= pwdata[0];
                default:             capacity_reg   <= capacity_reg;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_TARGET_CAPACITY: prdata = capacity_reg;
            REG_COUNT_ONLY:      prdata = {31'd0, count_only_reg};
            default:             prdata = '0;
        endcase
    end

    // Input register; room is kept in the queue for the item held in the stage.
    assign s_tready = ((QUEUE_CNT_W+1)'(qcnt_reg) + (QUEUE_CNT_W+1)'(st_valid_reg))
                      < (QUEUE_CNT_W+1)'(QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= s_tvalid && s_tready;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            st_char_reg    <= s_tdata;
            st_present_reg <= s_tuser;
            st_end_reg     <= s_tlast;
        end
    end

    // Character step, then the end-of-text flush, then the byte count and capacity check.
    always_comb begin
        code      = map_char(st_char_reg);
        char_live = st_valid_reg && st_present_reg && !stopped_reg;
        is_end    = st_valid_reg && st_end_reg;
        buf_mid   = buf_reg;
        cnt_mid   = cnt_reg;
        stop_mid  = stopped_reg;
        err_mid   = err_reg;
        group_evt = 1'b0;

        if (char_live) begin
            if (code == CODE_BAD) begin
                err_mid  = STATUS_BAD_CHAR;
                stop_mid = 1'b1;
            end else if (code == CODE_PAD) begin
                stop_mid = 1'b1;
            end else if (code != CODE_SKIP) begin
                if (cnt_reg != 2'd3) begin
                    buf_mid = {buf_reg[11:0], code[5:0]};
                    cnt_mid = cnt_reg + 2'd1;
                end else begin
                    group_evt = 1'b1;
                    buf_mid   = '0;
                    cnt_mid   = 2'd0;
                end
            end
        end

        flush3 = is_end && (err_mid == STATUS_OK) && (cnt_mid == 2'd3);
        flush2 = is_end && (err_mid == STATUS_OK) && (cnt_mid == 2'd2);

        if (group_evt) begin
            take_n = 2'd3;
        end else if (flush3) begin
            take_n = 2'd2;
        end else if (flush2) begin
            take_n = 2'd1;
        end else begin
            take_n = 2'd0;
        end

        sum       = {1'b0, total_reg} + 33'(take_n);
        over      = (take_n != 2'd0) && !count_only_reg && (sum > {1'b0, capacity_reg});
        emit      = (take_n != 2'd0) && !count_only_reg && !over;
        total_mid = total_reg;
        err_fin   = err_mid;
        stop_fin  = stop_mid;

        if (take_n != 2'd0) begin
            if (count_only_reg) begin
                total_mid = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            end else if (over) begin
                err_fin  = STATUS_OVERFLOW;
                stop_fin = 1'b1;
            end else begin
                total_mid = sum[31:0];
            end
        end

        // Bytes of this item, first byte in the top bits.
        if (group_evt) begin
            grp.bytes = {buf_reg, code[5:0]};
        end else if (flush3) begin
            grp.bytes = {buf_mid[17:10], buf_mid[9:2], 8'h00};
        end else begin
            grp.bytes = {buf_mid[11:4], 16'h0000};
        end
        grp.nbytes = emit ? take_n : 2'd0;
        grp.report = is_end;
        grp.status = err_fin;
        grp.count  = total_mid;
        push       = st_valid_reg && ((grp.nbytes != 2'd0) || is_end);

        // A report returns the decoder to its reset state.
        if (is_end) begin
            buf_next     = '0;
            cnt_next     = 2'd0;
            total_next   = '0;
            stopped_next = 1'b0;
            err_next     = STATUS_OK;
        end else begin
            buf_next     = buf_mid;
            cnt_next     = cnt_mid;
            total_next   = total_mid;
            stopped_next = stop_fin;
            err_next     = err_fin;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            cnt_reg     <= 2'd0;
            total_reg   <= '0;
            stopped_reg <= 1'b0;
            err_reg     <= STATUS_OK;
        end else begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            total_reg   <= total_next;
            stopped_reg <= stopped_next;
            err_reg     <= err_next;
        end
    end

    // Group queue.
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= grp;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            qcnt_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            qcnt_reg <= qcnt_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
        end
    end

    // Result selection from the head group.
    assign head     = queue_reg[rd_ptr_reg];
    assign nres     = 3'(head.nbytes) + 3'(head.report);
    assign res_last = (3'(idx_reg) + 3'd1) == nres;
    assign load     = (qcnt_reg != '0) && (!m_valid_reg || m_tready);
    assign pop      = load && res_last;

    always_comb begin
        case (idx_reg)
            2'd0:    sel_byte = head.bytes[23:16];
            2'd1:    sel_byte = head.bytes[15:8];
            2'd2:    sel_byte = head.bytes[7:0];
            default: sel_byte = 8'h00;
        endcase
    end

    // Output register and position within the head group.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            idx_reg     <= 2'd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                idx_reg     <= res_last ? 2'd0 : idx_reg + 2'd1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_last_reg <= res_last;
            if (idx_reg < head.nbytes) begin
                m_kind_reg   <= KIND_DATA;
                m_byte_reg   <= sel_byte;
                m_status_reg <= STATUS_OK;
                m_count_reg  <= '0;
            end else begin
                m_kind_reg   <= KIND_REPORT;
                m_byte_reg   <= 8'h00;
                m_status_reg <= head.status;
                m_count_reg  <= head.count;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_count_reg, m_status_reg, m_byte_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

// ----- tb/base64_stream_decoder_tb.sv -----
// Self-checking testbench for the base64 stream decoder: directed texts, then random texts.
module base64_stream_decoder_tb;
    import b64sd_pkg::*;

    localparam int IDLE_LIMIT       = 1000;
    localparam int DRAIN_CYCLES     = 16;
    localparam int SHOWN_MISMATCHES = 10;

    localparam logic [7:0] CHAR_LF  = 8'h0A;
    localparam logic [7:0] CHAR_PAD = 8'h3D;

    // One result transfer as the decoder should produce it.
    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [31:0] count;
        logic        last;
    } result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    wire         s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tuser  = 1'b0;
    logic        s_tlast  = 1'b0;
    wire         m_tvalid;
    logic        m_tready = 1'b0;
    wire  [47:0] m_tdata;
    wire         m_tuser;
    wire         m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'h0;
    wire  [31:0] prdata;
    wire         pready;

    // Decoder state and register copies kept by the testbench.
    logic [17:0] sextet_buf;
    logic [1:0]  sextet_cnt;
    logic [31:0] byte_total;
    logic        text_stopped;
    logic [1:0]  text_status;
    logic [31:0] capacity_reg;
    logic        count_only_reg;

    result_t decoded_results[$];
    int      mismatch_count = 0;
    int      items_sent     = 0;
    int      burst_left     = 0;
    int      idle_cycles    = 0;
    int unsigned sink_cycle = 0;

    base64_stream_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    // Value of a text byte in the alphabet, or its special class.
    function automatic logic [6:0] char_class(input logic [7:0] ch);
        logic [7:0] value;
        value = 8'd0;
        if (ch >= "A" && ch <= "Z") begin
            value = ch - "A";
        end else if (ch >= "a" && ch <= "z") begin
            value = ch - "a" + 8'd26;
        end else if (ch >= "0" && ch <= "9") begin
            value = ch - "0" + 8'd52;
        end else if (ch == "+") begin
            value = 8'd62;
        end else if (ch == "/") begin
            value = 8'd63;
        end else if (ch == CHAR_LF) begin
            return CODE_SKIP;
        end else if (ch == CHAR_PAD) begin
            return CODE_PAD;
        end else begin
            return CODE_BAD;
        end
        return value[6:0];
    endfunction

    // Text character that stands for a 6-bit value.
    function automatic logic [7:0] alphabet_char(input logic [5:0] v);
        logic [7:0] w;
        w = {2'b00, v};
        if (w < 8'd26) return "A" + w;
        if (w < 8'd52) return "a" + (w - 8'd26);
        if (w < 8'd62) return "0" + (w - 8'd52);
        if (w == 8'd62) return "+";
        return "/";
    endfunction

    // Adds n bytes to the running total unless they overflow the capacity; returns 1 when they go out as data.
    function automatic logic claim_bytes(input int unsigned n);
        logic [32:0] sum;
        sum = {1'b0, byte_total} + 33'(n);
        if (count_only_reg) begin
            byte_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            return 1'b0;
        end
        if (sum > {1'b0, capacity_reg}) begin
            text_status  = STATUS_OVERFLOW;
            text_stopped = 1'b1;
            return 1'b0;
        end
        byte_total = sum[31:0];
        return 1'b1;
    endfunction

    function automatic void push_result(input logic kind, input logic [7:0] data,
                                        input logic [1:0] status, input logic [31:0] count);
        result_t r;
        r.kind   = kind;
        r.data   = data;
        r.status = status;
        r.count  = count;
        r.last   = 1'b0;
        decoded_results.push_back(r);
    endfunction

    function automatic void clear_text_state();
        sextet_buf   = '0;
        sextet_cnt   = '0;
        byte_total   = '0;
        text_stopped = 1'b0;
        text_status  = STATUS_OK;
    endfunction

    // Works out the results that one accepted input transfer causes.
    function automatic void decode_text_item(input logic [7:0] ch, input logic present,
                                             input logic eot);
        logic [6:0]  cls;
        logic [23:0] grp;
        int          run_start;
        result_t     r;
        run_start = decoded_results.size();
        if (present && !text_stopped) begin
            cls = char_class(ch);
            if (cls == CODE_BAD) begin
                text_status  = STATUS_BAD_CHAR;
                text_stopped = 1'b1;
            end else if (cls == CODE_PAD) begin
                text_stopped = 1'b1;
            end else if (cls != CODE_SKIP) begin
                if (sextet_cnt < 2'd3) begin
                    sextet_buf = {sextet_buf[11:0], cls[5:0]};
                    sextet_cnt = sextet_cnt + 2'd1;
                end else begin
                    grp        = {sextet_buf, cls[5:0]};
                    sextet_buf = '0;
                    sextet_cnt = '0;
                    if (claim_bytes(3)) begin
                        push_result(KIND_DATA, grp[23:16], STATUS_OK, 32'd0);
                        push_result(KIND_DATA, grp[15:8], STATUS_OK, 32'd0);
                        push_result(KIND_DATA, grp[7:0], STATUS_OK, 32'd0);
                    end
                end
            end
        end
        if (eot) begin
            // Leftover values are flushed only when no error was seen.
            if (text_status == STATUS_OK) begin
                if (sextet_cnt == 2'd3) begin
                    if (claim_bytes(2)) begin
                        push_result(KIND_DATA, sextet_buf[17:10], STATUS_OK, 32'd0);
                        push_result(KIND_DATA, sextet_buf[9:2], STATUS_OK, 32'd0);
                    end
                end else if (sextet_cnt == 2'd2) begin
                    if (claim_bytes(1)) begin
                        push_result(KIND_DATA, sextet_buf[11:4], STATUS_OK, 32'd0);
                    end
                end
            end
            push_result(KIND_REPORT, 8'h00, text_status, byte_total);
            clear_text_state();
        end
        if (decoded_results.size() > run_start) begin
            r = decoded_results.pop_back();
            r.last = 1'b1;
            decoded_results.push_back(r);
        end
    endfunction

    // Sends one input transfer; the sender can idle between bursts of random length.
    task automatic send_item(input logic [7:0] code, input logic present, input logic eot);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= code;
        s_tuser  <= present;
        s_tlast  <= eot;
        do @(posedge aclk); while (!s_tready);
        decode_text_item(code, present, eot);
        if (present || eot) items_sent++;
    endtask

    task automatic send_string(input string txt, input logic eot_on_last);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], 1'b1, eot_on_last && (i == txt.len() - 1));
        end
    endtask

    // Lowers tvalid, waits for every awaited result, then lets the pipeline empty.
    task automatic drain_decoder();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (decoded_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (idx == REG_TARGET_CAPACITY) begin
            capacity_reg = value;
        end else begin
            count_only_reg = value[0];
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure(input logic [31:0] capacity, input logic count_only);
        drain_decoder();
        write_register(REG_TARGET_CAPACITY, capacity);
        write_register(REG_COUNT_ONLY, {31'd0, count_only});
    endtask

    // One random text; most are clean base64, the rest carry pads, bad bytes and empty items.
    task automatic send_random_text();
        int         len;
        int         pick;
        logic       clean;
        logic       eot_on_last;
        logic [7:0] code;
        len         = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 16);
        clean       = $urandom_range(0, 9) < 6;
        eot_on_last = 1'($urandom_range(0, 1));
        for (int i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 80 || (clean && pick < 95)) begin
                code = alphabet_char(6'($urandom_range(0, 63)));
            end else if (clean || pick < 86) begin
                code = CHAR_LF;
            end else if (pick < 89) begin
                code = CHAR_PAD;
            end else if (pick < 94) begin
                code = 8'($urandom_range(0, 255));
            end else begin
                // A transfer with neither flag set must leave the decoder untouched.
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
                code = alphabet_char(6'($urandom_range(0, 63)));
            end
            send_item(code, 1'b1, eot_on_last && (i == len - 1));
        end
        if (!(eot_on_last && len > 0)) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    task automatic test_alphabet_and_skip();
        send_string("AZaz09+/\n", 1'b0);
        send_item(CHAR_PAD, 1'b1, 1'b1);
    endtask

    task automatic test_leftovers_and_pad();
        // Three leftover values give two bytes at a separate end marker.
        send_string("QUJ", 1'b0);
        send_item(8'hA5, 1'b0, 1'b1);
        // The pad stops decoding, yet the leftover of two still gives a byte.
        send_string("QQ=", 1'b1);
        // A single leftover value gives nothing.
        send_string("Q", 1'b1);
    endtask

    task automatic test_invalid_character();
        send_string("QUJ", 1'b0);
        send_item(8'h80, 1'b1, 1'b0);
        send_string("A", 1'b1);
    endtask

    task automatic test_capacity_overflow();
        configure(32'd2, 1'b0);
        send_string("AAAA", 1'b1);
    endtask

    task automatic test_count_only();
        configure(32'd0, 1'b1);
        send_string("QUJDQQ", 1'b1);
    endtask

    task automatic test_random_texts(input logic [31:0] capacity, input logic count_only,
                                     input int items);
        int stop_at;
        configure(capacity, count_only);
        stop_at = items_sent + items;
        while (items_sent < stop_at) send_random_text();
    endtask

    // Receiver ready pattern: always ready, coin flips, a fixed rhythm, rare stalls.
    always @(negedge aclk) begin
        sink_cycle <= sink_cycle + 1;
        case ((sink_cycle >> 8) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (sink_cycle % 5) > 1;
            default: m_tready <= $urandom_range(0, 9) != 0;
        endcase
    end

    // Compares each result transfer with the oldest awaited one.
    always @(posedge aclk) begin : check_results
        result_t want;
        result_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[41:10], m_tlast};
            if (decoded_results.size() == 0) begin
                if (mismatch_count < SHOWN_MISMATCHES) begin
                    $display("unexpected result: kind %0d data %02h status %0d",
                             got.kind, got.data, got.status,
                             " count %0d last %0d", got.count, got.last);
                end
                mismatch_count++;
            end else begin
                want = decoded_results.pop_front();
                if (got != want || m_tdata[47:42] != 6'd0) begin
                    if (mismatch_count < SHOWN_MISMATCHES) begin
                        $display("mismatch: expected kind %0d data %02h status %0d",
                                 want.kind, want.data, want.status,
                                 " count %0d last %0d", want.count, want.last);
                        $display("          actual   kind %0d data %02h status %0d",
                                 got.kind, got.data, got.status,
                                 " count %0d last %0d pad %02h", got.count, got.last,
                                 m_tdata[47:42]);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // Ends the run when no transfer of any kind happens for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without a transfer", idle_cycles);
            $display("base64_stream_decoder_tb NOT OK");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        capacity_reg   = 32'd0;
        count_only_reg = 1'b0;
        clear_text_state();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        configure(32'hFFFF_FFFF, 1'b0);
        test_alphabet_and_skip();
        test_leftovers_and_pad();
        test_invalid_character();
        test_capacity_overflow();
        test_count_only();

        test_random_texts(32'hFFFF_FFFF, 1'b0, 90);
        test_random_texts(32'd0, 1'b0, 40);
        test_random_texts(32'($urandom_range(0, 20)), 1'b0, 70);
        test_random_texts($urandom, 1'b1, 60);
        test_random_texts($urandom, 1'b0, 40);

        drain_decoder();
        if (mismatch_count == 0 && decoded_results.size() == 0) begin
            $display("base64_stream_decoder_tb OK");
        end else begin
            $display("base64_stream_decoder_tb NOT OK");
        end
        $finish;
    end

endmodule
